[rtl/core/tges_pkg.sv]
// Shared constants, codes and helpers for the tile grid edge segment extractor.
`default_nettype none

package tges_pkg;

   localparam int ROW_BITS_W = 16;
   localparam int ROW_W      = 5;
   localparam int KIND_W     = 3;
   localparam int COORD_W    = 11;
   localparam int TILE_W     = 7;
   localparam int BND_W      = 2;
   localparam int CSR_IDX_W  = 1;

   localparam int GRID_WIDTH_DEF  = 16;
   localparam int GRID_HEIGHT_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [TILE_W-1:0] TILE_SIZE_RESET = 7'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT = 1'd1;

   localparam logic [BND_W-1:0] B_NONE  = 2'd0;
   localparam logic [BND_W-1:0] B_LEFT  = 2'd1;
   localparam logic [BND_W-1:0] B_RIGHT = 2'd2;

   localparam logic [KIND_W-1:0] K_TOP       = 3'd0;
   localparam logic [KIND_W-1:0] K_BOTTOM    = 3'd1;
   localparam logic [KIND_W-1:0] K_MIDDLE    = 3'd2;
   localparam logic [KIND_W-1:0] K_LEFTEDGE  = 3'd3;
   localparam logic [KIND_W-1:0] K_RIGHTEDGE = 3'd4;

   // tile size times a tile index, kept to the coordinate width
   function automatic logic [COORD_W-1:0] scale(input logic [TILE_W-1:0] size,
                                                input logic [ROW_W-1:0] index);
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      a = {{(COORD_W-TILE_W){1'b0}}, size};
      b = {{(COORD_W-ROW_W){1'b0}}, index};
      return a * b;
   endfunction

endpackage

`default_nettype wire

[rtl/core/tges_queue.sv]
// Small first-in first-out queue of classified requests between front and back.
`default_nettype none

module tges_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             nonempty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata    = data_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);

endmodule

`default_nettype wire

[rtl/core/tges_front.sv]
// Front end: accepts rows, compares boundaries in parallel, tracks open vertical runs.
`default_nettype none

module tges_front #(
   parameter int GRID_WIDTH  = tges_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tges_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_op,
   input  logic [tges_pkg::ROW_BITS_W-1:0]           req_row_bits,
   input  logic                                      q_full,
   output logic                                      q_push,
   output logic [tges_pkg::ROW_W-1:0]                ent_row,
   output logic [tges_pkg::KIND_W-1:0]               ent_hkind,
   output logic [GRID_WIDTH:0]                       ent_hchg,
   output logic [GRID_WIDTH:0]                       ent_hend,
   output logic [GRID_WIDTH:0]                       ent_hdir,
   output logic [GRID_WIDTH:0]                       ent_vclose,
   output logic [GRID_WIDTH:0]                       ent_vdir,
   output logic [GRID_WIDTH:0][tges_pkg::ROW_W-1:0]  ent_vstart
);

   import tges_pkg::*;

   localparam int LINES = GRID_WIDTH + 1;

   logic [GRID_WIDTH-1:0]            prev_row_ff, prev_row_in;
   logic [ROW_W-1:0]                 row_count_ff, row_count_in;
   logic [LINES-1:0][BND_W-1:0]      col_kind_ff, col_kind_in;
   logic [LINES-1:0][ROW_W-1:0]      col_start_ff, col_start_in;

   logic [GRID_WIDTH-1:0]            bits;
   logic [LINES-1:0]                 bits_hi, bits_lo, above, below;
   logic [LINES-1:0][BND_W-1:0]      nbh, nbh_prev, nbv;
   logic                             first_row, accept, extra, live;

   always_comb begin
      bits      = req_row_bits[GRID_WIDTH-1:0];
      bits_hi   = {1'b1, bits};
      bits_lo   = {bits, 1'b1};
      first_row = (row_count_ff == '0);
      above     = {1'b1, prev_row_ff} | {LINES{first_row}};
      below     = bits_hi | {LINES{req_op}};

      for (int t = 0; t < LINES; t++) begin
         nbh[t] = (above[t] && !below[t]) ? B_LEFT :
                  (below[t] && !above[t]) ? B_RIGHT : B_NONE;
      end
      nbh_prev[0] = B_NONE;
      for (int t = 1; t < LINES; t++) begin
         nbh_prev[t] = nbh[t-1];
      end
      for (int t = 0; t < LINES; t++) begin
         ent_hchg[t] = (nbh[t] != nbh_prev[t]);
         ent_hend[t] = (nbh[t] != nbh_prev[t]) && (nbh_prev[t] != B_NONE);
         ent_hdir[t] = (nbh_prev[t] == B_RIGHT);
      end

      for (int c = 0; c < LINES; c++) begin
         if (req_op) begin
            nbv[c] = B_NONE;
         end else begin
            nbv[c] = (bits_lo[c] && !bits_hi[c]) ? B_RIGHT :
                     (bits_hi[c] && !bits_lo[c]) ? B_LEFT : B_NONE;
         end
         ent_vclose[c] = (nbv[c] != col_kind_ff[c]) && (col_kind_ff[c] != B_NONE);
         ent_vdir[c]   = (col_kind_ff[c] == B_RIGHT);
         ent_vstart[c] = col_start_ff[c];
      end

      ent_row   = row_count_ff;
      ent_hkind = first_row ? K_TOP : (req_op ? K_BOTTOM : K_MIDDLE);

      req_stall = q_full;
      accept    = req_valid && !q_full;
      extra     = !req_op && (row_count_ff >= ROW_W'(GRID_HEIGHT));
      live      = accept && !extra;
      q_push    = live && ((|ent_hend) || (|ent_vclose));

      prev_row_in  = prev_row_ff;
      row_count_in = row_count_ff;
      col_kind_in  = col_kind_ff;
      col_start_in = col_start_ff;
      if (live) begin
         if (req_op) begin
            prev_row_in  = '0;
            row_count_in = '0;
            for (int c = 0; c < LINES; c++) begin
               col_kind_in[c]  = B_NONE;
               col_start_in[c] = '0;
            end
         end else begin
            prev_row_in  = bits;
            row_count_in = row_count_ff + ROW_W'(1);
            for (int c = 0; c < LINES; c++) begin
               col_kind_in[c] = nbv[c];
               if ((nbv[c] != col_kind_ff[c]) && (nbv[c] != B_NONE)) begin
                  col_start_in[c] = row_count_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_row_ff  <= '0;
         row_count_ff <= '0;
         for (int c = 0; c < LINES; c++) begin
            col_kind_ff[c]  <= B_NONE;
            col_start_ff[c] <= '0;
         end
      end else begin
         prev_row_ff  <= prev_row_in;
         row_count_ff <= row_count_in;
         col_kind_ff  <= col_kind_in;
         col_start_ff <= col_start_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/tges_back.sv]
// Back end: walks a queued request's change points; at most one segment per cycle.
`default_nettype none

module tges_back #(
   parameter int GRID_WIDTH = tges_pkg::GRID_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      q_valid,
   output logic                                      q_pop,
   input  logic [tges_pkg::ROW_W-1:0]                q_row,
   input  logic [tges_pkg::KIND_W-1:0]               q_hkind,
   input  logic [GRID_WIDTH:0]                       q_hchg,
   input  logic [GRID_WIDTH:0]                       q_hend,
   input  logic [GRID_WIDTH:0]                       q_hdir,
   input  logic [GRID_WIDTH:0]                       q_vclose,
   input  logic [GRID_WIDTH:0]                       q_vdir,
   input  logic [GRID_WIDTH:0][tges_pkg::ROW_W-1:0]  q_vstart,
   input  logic [tges_pkg::TILE_W-1:0]               tile_width,
   input  logic [tges_pkg::TILE_W-1:0]               tile_height,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [tges_pkg::KIND_W-1:0]               rsp_list_kind,
   output logic [tges_pkg::COORD_W-1:0]              rsp_start_x,
   output logic [tges_pkg::COORD_W-1:0]              rsp_start_y,
   output logic [tges_pkg::COORD_W-1:0]              rsp_end_x,
   output logic [tges_pkg::COORD_W-1:0]              rsp_end_y,
   output logic                                      rsp_last_of_run
);

   import tges_pkg::*;

   localparam int LINES  = GRID_WIDTH + 1;
   localparam int SCAN   = 2 * LINES;
   localparam int POS_W  = $clog2(LINES);
   localparam int SCAN_W = $clog2(SCAN);

   logic [SCAN-1:0]    visited_ff, visited_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic               last_ff, last_in;

   logic [SCAN-1:0]    scan, emits, remain, lowbit, above_mask;
   logic [SCAN_W-1:0]  pos;
   logic [POS_W-1:0]   t, col;
   logic               horiz, emit, dir, last, out_free, advance;
   logic [ROW_W-1:0]   pa, pb, qa, qb;
   logic [KIND_W-1:0]  kind;
   logic [COORD_W-1:0] xa, xb, ya, yb;

   always_comb begin
      scan       = {q_vclose, q_hchg};
      emits      = {q_vclose, q_hend};
      remain     = scan & ~visited_ff;
      lowbit     = remain & (~remain + SCAN'(1));
      above_mask = ~(lowbit | (lowbit - SCAN'(1)));
      last       = ((emits & above_mask) == '0);

      pos = '0;
      for (int i = 0; i < SCAN; i++) begin
         if (lowbit[i]) begin
            pos = pos | SCAN_W'(i);
         end
      end
      horiz = (pos < SCAN_W'(LINES));
      t     = pos[POS_W-1:0];
      col   = POS_W'(pos - SCAN_W'(LINES));

      if (horiz) begin
         emit = q_hend[t];
         dir  = q_hdir[t];
         pa   = ROW_W'(start_ff);
         pb   = ROW_W'(t);
         qa   = q_row;
         qb   = q_row;
         kind = q_hkind;
      end else begin
         emit = 1'b1;
         dir  = q_vdir[col];
         pa   = ROW_W'(col);
         pb   = ROW_W'(col);
         qa   = q_vstart[col];
         qb   = q_row;
         kind = (col == '0) ? K_LEFTEDGE :
                (col == POS_W'(GRID_WIDTH)) ? K_RIGHTEDGE : K_MIDDLE;
      end

      xa = scale(tile_width, pa);
      xb = scale(tile_width, pb);
      ya = scale(tile_height, qa);
      yb = scale(tile_height, qb);

      out_free = !rsp_valid_ff || !rsp_stall;
      advance  = q_valid && out_free;
      q_pop    = advance && (remain == lowbit);

      visited_in = visited_ff;
      start_in   = start_ff;
      if (advance) begin
         visited_in = q_pop ? '0 : (visited_ff | lowbit);
         if (horiz) begin
            start_in = t;
         end
      end

      rsp_valid_in = out_free ? (advance && emit) : rsp_valid_ff;
      kind_in = kind_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      ex_in   = ex_ff;
      ey_in   = ey_ff;
      last_in = last_ff;
      if (advance && emit) begin
         kind_in = kind;
         last_in = last;
         if (dir) begin
            sx_in = xa;
            sy_in = ya;
            ex_in = xb;
            ey_in = yb;
         end else begin
            sx_in = xb;
            sy_in = yb;
            ex_in = xa;
            ey_in = ya;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      kind_ff  <= kind_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_list_kind   = kind_ff;
   assign rsp_start_x     = sx_ff;
   assign rsp_start_y     = sy_ff;
   assign rsp_end_x       = ex_ff;
   assign rsp_end_y       = ey_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

[rtl/core/tile_grid_edge_segment_extractor_core.sv]
// Top level of the tile grid edge segment extractor: front end, queue, back end, CSRs.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  op, row_bits
//   rsp_*        out   rsp_valid/rsp_stall  list_kind, start/end x/y, last_of_run
//   csr_*        in    csr_write_en         index, wdata (tile width, tile height)
//
// The front end takes one request per cycle while the queue has room.
// The back end steps through each boundary change on the row line, then each
// closed vertical run: up to 2 * (GRID_WIDTH + 1) change points, 34 for a 16-wide grid.
// A request that yields no segment costs the back end nothing.
// Reset is synchronous; it clears the grid state, the queue and the output valid.
// rsp_stall holds the output register; the queue lets requests keep coming meanwhile until it is full.
`default_nettype none

module tile_grid_edge_segment_extractor_core #(
   parameter int GRID_WIDTH  = tges_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tges_pkg::GRID_HEIGHT_DEF,
   parameter int QUEUE_DEPTH = tges_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [tges_pkg::ROW_BITS_W-1:0]   req_row_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tges_pkg::KIND_W-1:0]       rsp_list_kind,
   output logic [tges_pkg::COORD_W-1:0]      rsp_start_x,
   output logic [tges_pkg::COORD_W-1:0]      rsp_start_y,
   output logic [tges_pkg::COORD_W-1:0]      rsp_end_x,
   output logic [tges_pkg::COORD_W-1:0]      rsp_end_y,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_en,
   input  logic [tges_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tges_pkg::TILE_W-1:0]       csr_wdata
);

   import tges_pkg::*;

   localparam int LINES = GRID_WIDTH + 1;
   localparam int QW    = ROW_W + KIND_W + 5 * LINES + LINES * ROW_W;

   logic [TILE_W-1:0] tile_width_ff, tile_width_in;
   logic [TILE_W-1:0] tile_height_ff, tile_height_in;

   logic                         q_push, q_pop, q_full, q_valid;
   logic [QW-1:0]                q_wdata, q_rdata;

   logic [ROW_W-1:0]             f_row, b_row;
   logic [KIND_W-1:0]            f_hkind, b_hkind;
   logic [LINES-1:0]             f_hchg, f_hend, f_hdir, f_vclose, f_vdir;
   logic [LINES-1:0]             b_hchg, b_hend, b_hdir, b_vclose, b_vdir;
   logic [LINES-1:0][ROW_W-1:0]  f_vstart, b_vstart;

   always_comb begin
      tile_width_in  = tile_width_ff;
      tile_height_in = tile_height_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_TILE_WIDTH) begin
            tile_width_in = csr_wdata;
         end else if (csr_index == CSR_TILE_HEIGHT) begin
            tile_height_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= TILE_SIZE_RESET;
         tile_height_ff <= TILE_SIZE_RESET;
      end else begin
         tile_width_ff  <= tile_width_in;
         tile_height_ff <= tile_height_in;
      end
   end

   tges_front #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_row_bits (req_row_bits),
      .q_full       (q_full),
      .q_push       (q_push),
      .ent_row      (f_row),
      .ent_hkind    (f_hkind),
      .ent_hchg     (f_hchg),
      .ent_hend     (f_hend),
      .ent_hdir     (f_hdir),
      .ent_vclose   (f_vclose),
      .ent_vdir     (f_vdir),
      .ent_vstart   (f_vstart)
   );

   assign q_wdata = {f_row, f_hkind, f_hchg, f_hend, f_hdir, f_vclose, f_vdir, f_vstart};

   tges_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wdata    (q_wdata),
      .pop      (q_pop),
      .rdata    (q_rdata),
      .full     (q_full),
      .nonempty (q_valid)
   );

   assign {b_row, b_hkind, b_hchg, b_hend, b_hdir, b_vclose, b_vdir, b_vstart} = q_rdata;

   tges_back #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_row           (b_row),
      .q_hkind         (b_hkind),
      .q_hchg          (b_hchg),
      .q_hend          (b_hend),
      .q_hdir          (b_hdir),
      .q_vclose        (b_vclose),
      .q_vdir          (b_vdir),
      .q_vstart        (b_vstart),
      .tile_width      (tile_width_ff),
      .tile_height     (tile_height_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_list_kind   (rsp_list_kind),
      .rsp_start_x     (rsp_start_x),
      .rsp_start_y     (rsp_start_y),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_horizontal_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_list_kind == K_TOP || rsp_list_kind == K_BOTTOM))
         |-> (rsp_start_y == rsp_end_y))
      else $error("top or bottom segment is not horizontal");

   a_vertical_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_list_kind == K_LEFTEDGE || rsp_list_kind == K_RIGHTEDGE))
         |-> (rsp_start_x == rsp_end_x))
      else $error("grid edge segment is not vertical");

endmodule

`default_nettype wire

[verif/tile_grid_edge_segment_extractor_core_test.sv]
// Testbench for the tile grid edge segment extractor core: scoreboard, request drivers, checks.
`timescale 1ns / 100ps

import tges_pkg::*;

typedef struct packed {
   logic [KIND_W-1:0]  kind;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic               last_of_run;
} segment_type;

class edge_tracker_type;
   logic [TILE_W-1:0]     tile_w;
   logic [TILE_W-1:0]     tile_h;
   logic [ROW_BITS_W-1:0] last_row;
   logic [ROW_W-1:0]      rows_seen;
   logic [BND_W-1:0]      run_kind [GRID_WIDTH_DEF+1];
   logic [ROW_W-1:0]      run_from [GRID_WIDTH_DEF+1];
   segment_type           expected_q [$];
   segment_type           held;
   bit                    have_held;
   int unsigned           requests_used;
   int unsigned           grids_closed;
   int unsigned           segments_checked;
   int unsigned           mismatches;

   function new();
      tile_w = TILE_SIZE_RESET;
      tile_h = TILE_SIZE_RESET;
      have_held = 1'b0;
      requests_used = 0;
      grids_closed = 0;
      segments_checked = 0;
      mismatches = 0;
      clear_grid();
   endfunction

   function void clear_grid();
      last_row = '0;
      rows_seen = '0;
      for (int c = 0; c <= GRID_WIDTH_DEF; c++) begin
         run_kind[c] = B_NONE;
         run_from[c] = '0;
      end
   endfunction

   function void set_register(input logic [CSR_IDX_W-1:0] index,
                              input logic [TILE_W-1:0] value);
      if (index == CSR_TILE_WIDTH) begin
         tile_w = value;
      end else if (index == CSR_TILE_HEIGHT) begin
         tile_h = value;
      end
   endfunction

   function logic [COORD_W-1:0] pixel(input logic [TILE_W-1:0] size, input int idx);
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      a = {{(COORD_W-TILE_W){1'b0}}, size};
      b = idx[COORD_W-1:0];
      return a * b;
   endfunction

   function logic tile_at(input logic [ROW_BITS_W-1:0] mask, input int idx);
      return (idx >= 0 && idx < GRID_WIDTH_DEF) ? mask[idx] : 1'b0;
   endfunction

   // one segment is held back so the final one of a request can be flagged
   function void hold_segment(input logic [KIND_W-1:0] kind,
                              input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
      if (have_held) expected_q.insert(expected_q.size(), held);
      held.kind = kind;
      held.start_x = sx;
      held.start_y = sy;
      held.end_x = ex;
      held.end_y = ey;
      held.last_of_run = 1'b0;
      have_held = 1'b1;
   endfunction

   function void note_request(input logic op, input logic [ROW_BITS_W-1:0] bits);
      logic [KIND_W-1:0]  kind;
      logic [KIND_W-1:0]  vkind;
      logic [BND_W-1:0]   cur;
      logic [BND_W-1:0]   nb;
      logic [BND_W-1:0]   was;
      logic               above;
      logic               below;
      logic               lft;
      logic               rgt;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
      int                 start_col;
      if (!op && rows_seen >= GRID_HEIGHT_DEF) return;
      requests_used++;
      if (op && rows_seen != 0) grids_closed++;

      // horizontal line at the current row
      kind = (rows_seen == 0) ? K_TOP : (op ? K_BOTTOM : K_MIDDLE);
      y = pixel(tile_h, int'(rows_seen));
      cur = B_NONE;
      start_col = 0;
      for (int t = 0; t <= GRID_WIDTH_DEF; t++) begin
         above = (t == GRID_WIDTH_DEF) || (rows_seen == 0) || tile_at(last_row, t);
         below = (t == GRID_WIDTH_DEF) || op || tile_at(bits, t);
         nb = (above && !below) ? B_LEFT : (below && !above) ? B_RIGHT : B_NONE;
         if (nb != cur) begin
            if (cur == B_RIGHT) begin
               hold_segment(kind, pixel(tile_w, start_col), y, pixel(tile_w, t), y);
            end else if (cur == B_LEFT) begin
               hold_segment(kind, pixel(tile_w, t), y, pixel(tile_w, start_col), y);
            end
            if (nb != B_NONE) start_col = t;
            cur = nb;
         end
      end

      // vertical runs per column line
      for (int c = 0; c <= GRID_WIDTH_DEF; c++) begin
         vkind = (c == 0) ? K_LEFTEDGE : (c == GRID_WIDTH_DEF) ? K_RIGHTEDGE : K_MIDDLE;
         was = run_kind[c];
         nb = B_NONE;
         if (!op) begin
            lft = (c == 0) || tile_at(bits, c - 1);
            rgt = (c == GRID_WIDTH_DEF) || tile_at(bits, c);
            nb = (lft && !rgt) ? B_RIGHT : (rgt && !lft) ? B_LEFT : B_NONE;
         end
         if (nb != was) begin
            x = pixel(tile_w, c);
            if (was == B_RIGHT) begin
               hold_segment(vkind, x, pixel(tile_h, int'(run_from[c])), x, y);
            end else if (was == B_LEFT) begin
               hold_segment(vkind, x, y, x, pixel(tile_h, int'(run_from[c])));
            end
            if (nb != B_NONE) run_from[c] = rows_seen;
            run_kind[c] = nb;
         end
      end

      if (!op) begin
         last_row = bits;
         rows_seen = rows_seen + 1'b1;
      end else begin
         clear_grid();
      end

      if (have_held) begin
         held.last_of_run = 1'b1;
         expected_q.insert(expected_q.size(), held);
         have_held = 1'b0;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function void check_segment(input segment_type got);
      segment_type want;
      if (expected_q.size() == 0) begin
         $display("%0t ns: unexpected segment, expected none, actual kind %0d (%0d,%0d)->(%0d,%0d)",
                  $time, got.kind, got.start_x, got.start_y, got.end_x, got.end_y);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      segments_checked++;
      compare_field("list_kind", want.kind, got.kind);
      compare_field("start_x", want.start_x, got.start_x);
      compare_field("start_y", want.start_y, got.start_y);
      compare_field("end_x", want.end_x, got.end_x);
      compare_field("end_y", want.end_y, got.end_y);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
   endfunction
endclass

module tile_grid_edge_segment_extractor_core_test;
   localparam logic OP_ROW          = 1'b0;
   localparam logic OP_FINISH       = 1'b1;
   localparam int   ROWS            = GRID_HEIGHT_DEF;
   localparam int   PHASES          = 6;
   localparam int   ITEMS_PER_PHASE = 72;
   localparam int   DRAIN_CYCLES    = 120;
   localparam int   HOLD_CYCLES     = 400;
   localparam int   QUIET_LIMIT     = 4000;

   // a full grid plus one surplus row
   localparam logic [17*16-1:0] SHAPES = {
      16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8001, 16'h7FFE, 16'h0001, 16'h8000,
      16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'hFFFF, 16'h0000, 16'hC3C3,
      16'h5A5A};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = OP_ROW;
   logic [ROW_BITS_W-1:0] req_row_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_list_kind;
   logic [COORD_W-1:0]    rsp_start_x;
   logic [COORD_W-1:0]    rsp_start_y;
   logic [COORD_W-1:0]    rsp_end_x;
   logic [COORD_W-1:0]    rsp_end_y;
   logic                  rsp_last_of_run;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TILE_WIDTH;
   logic [TILE_W-1:0]     csr_wdata = TILE_SIZE_RESET;

   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_idle_pct = 0;
   bit               squeeze = 1'b0;
   edge_tracker_type tracker = new();

   tile_grid_edge_segment_extractor_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_row_bits    (req_row_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_list_kind   (rsp_list_kind),
      .rsp_start_x     (rsp_start_x),
      .rsp_start_y     (rsp_start_y),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic write_tile_size(input logic [TILE_W-1:0] w, input logic [TILE_W-1:0] h);
      csr_write_en <= 1'b1;
      csr_index <= CSR_TILE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      tracker.set_register(CSR_TILE_WIDTH, w);
      csr_index <= CSR_TILE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      tracker.set_register(CSR_TILE_HEIGHT, h);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_request(input logic op, input logic [ROW_BITS_W-1:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_row_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(op, bits);
   endtask

   task automatic random_grid();
      int                    pick;
      int                    depth;
      int                    extra;
      int                    style;
      int                    k;
      int                    lo;
      int                    hi;
      logic [31:0]           span;
      logic [ROW_BITS_W-1:0] bits;
      pick = $urandom_range(99);
      depth = (pick < 5) ? 0 : (pick < 20) ? ROWS :
              (pick < 65) ? $urandom_range(1, 6) : $urandom_range(7, ROWS);
      extra = (depth == ROWS && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      bits = ROW_BITS_W'($urandom);
      for (int r = 0; r < depth + extra; r++) begin
         style = $urandom_range(9);
         if (style < 5) begin
            // small changes keep vertical runs open across rows
            repeat ($urandom_range(2)) begin
               k = $urandom_range(15);
               bits[k] = ~bits[k];
            end
         end else if (style < 7) begin
            bits = ROW_BITS_W'($urandom);
         end else if (style < 8) begin
            bits = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
         end else begin
            lo = $urandom_range(15);
            hi = $urandom_range(lo, 15);
            span = ((32'd1 << (hi + 1)) - 32'd1) & ~((32'd1 << lo) - 32'd1);
            bits = span[ROW_BITS_W-1:0];
         end
         send_request(OP_ROW, bits);
      end
      bits = ROW_BITS_W'($urandom);
      send_request(OP_FINISH, bits);
   endtask

   task automatic settle();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int          hold_left;
      bit          squeezed;
      segment_type got;
      hold_left = 0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind = rsp_list_kind;
            got.start_x = rsp_start_x;
            got.start_y = rsp_start_y;
            got.end_x = rsp_end_x;
            got.end_y = rsp_end_y;
            got.last_of_run = rsp_last_of_run;
            tracker.check_segment(got);
         end
         if (squeeze && !squeezed) begin
            hold_left = HOLD_CYCLES;
            squeezed = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: %0d cycles without a request or segment", QUIET_LIMIT);
      $display("tile_grid_edge_segment_extractor_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [TILE_W-1:0] w;
      logic [TILE_W-1:0] h;
      int unsigned       mark;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = (p < 2) ? 30 : (p < 4) ? 45 : 0;
         rsp_idle_pct = (p < 2) ? 45 : (p < 4) ? 30 : 0;
         case (p)
            0: begin w = 7'd16; h = 7'd16; end
            1: begin w = 7'd1; h = 7'd64; end
            2: begin w = 7'd64; h = 7'd1; end
            3: begin w = 7'd0; h = 7'd127; end
            4: begin w = 7'd127; h = 7'd0; end
            default: begin
               w = TILE_W'($urandom_range(1, 64));
               h = TILE_W'($urandom_range(1, 64));
            end
         endcase
         write_tile_size(w, h);
         if (p == 0) begin
            // empty grid, one-row grid, full grid with a surplus row
            send_request(OP_FINISH, 16'hFFFF);
            send_request(OP_ROW, 16'h0000);
            send_request(OP_FINISH, 16'h0000);
            for (int i = 0; i <= ROWS; i++) send_request(OP_ROW, SHAPES[(ROWS - i) * 16 +: 16]);
            send_request(OP_FINISH, 16'h1234);
         end else begin
            if (p == 1) squeeze = 1'b1;
            mark = tracker.requests_used;
            while (tracker.requests_used - mark < ITEMS_PER_PHASE) random_grid();
         end
         req_valid <= 1'b0;
         settle();
      end
      $display("ran %0d requests in %0d closed grids under %0d tile-size settings",
               tracker.requests_used, tracker.grids_closed, PHASES);
      $display("compared %0d segments, %0d mismatches", tracker.segments_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("tile_grid_edge_segment_extractor_core regression: pass");
      else
         $display("tile_grid_edge_segment_extractor_core regression: fail");
      $finish;
   end
endmodule

[files.f]
rtl/core/tges_pkg.sv
rtl/core/tges_queue.sv
rtl/core/tges_front.sv
rtl/core/tges_back.sv
rtl/core/tile_grid_edge_segment_extractor_core.sv
verif/tile_grid_edge_segment_extractor_core_test.sv
